FILE: design/rdt_pkg.sv
// Package for the RPN decimal tokenizer: token kinds, operator codes,
// character constants, the queue entry flags and the operator decoder.
// No dependencies.
package rdt_pkg;

	typedef enum logic [1:0] {
		KIND_NUMBER   = 2'd0,
		KIND_OPERATOR = 2'd1,
		KIND_INVALID  = 2'd2,
		KIND_OVERFLOW = 2'd3
	} rdt_kind_t;

	localparam logic [3:0] OP_ADD      = 4'd0;
	localparam logic [3:0] OP_SUB      = 4'd1;
	localparam logic [3:0] OP_MUL      = 4'd2;
	localparam logic [3:0] OP_DIV      = 4'd3;
	localparam logic [3:0] OP_SHOW     = 4'd4;
	localparam logic [3:0] OP_SHOW_ALL = 4'd5;
	localparam logic [3:0] OP_WIPE     = 4'd6;
	localparam logic [3:0] OP_DUP      = 4'd7;
	localparam logic [3:0] OP_SWAP     = 4'd8;
	localparam logic [3:0] CODE_NONE   = 4'd0;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_R     = 8'h72;

	// Result flags of one queued item; the number value travels beside it
	typedef struct packed {
		logic      num_valid;
		logic      tail_valid;
		rdt_kind_t kind;
		logic [3:0] code;
	} rdt_tail_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] code;
	} rdt_op_t;

	function automatic rdt_op_t op_decode(input logic [7:0] ch);
		rdt_op_t op;
		op.hit  = 1'b1;
		op.code = CODE_NONE;
		case (ch)
			CH_PLUS:  op.code = OP_ADD;
			CH_MINUS: op.code = OP_SUB;
			CH_STAR:  op.code = OP_MUL;
			CH_SLASH: op.code = OP_DIV;
			CH_P:     op.code = OP_SHOW;
			CH_F:     op.code = OP_SHOW_ALL;
			CH_C:     op.code = OP_WIPE;
			CH_D:     op.code = OP_DUP;
			CH_R:     op.code = OP_SWAP;
			default:  op.hit  = 1'b0;
		endcase
		return op;
	endfunction

endpackage

FILE: design/rdt_front.sv
// Front end of the RPN decimal tokenizer: accepts characters, builds the
// decimal accumulator and pushes one queue entry per character that has results.
// Depends on rdt_pkg.
module rdt_front import rdt_pkg::*; #(
	parameter int VALUE_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_stall,
	input  logic [7:0]            character,
	input  logic                  full,
	output logic                  push,
	output logic [VALUE_BITS-1:0] push_value,
	output rdt_tail_t             push_tail
);

	localparam int PW = VALUE_BITS + 4;

	logic                  nip_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic                  accept;
	logic                  is_digit;
	logic [7:0]            digit_full;
	logic [PW-1:0]         acc_w;
	logic [PW-1:0]         prod;
	logic                  ovf;
	rdt_op_t               op;

	assign char_stall = full;
	assign accept     = char_valid && !full;

	always_comb begin
		is_digit   = character inside {[CH_ZERO:CH_NINE]};
		digit_full = character - CH_ZERO;
		acc_w      = {4'b0, acc_q};
		// times ten as eight plus two
		prod       = (acc_w << 3) + (acc_w << 1) + PW'(digit_full[3:0]);
		ovf        = |prod[PW-1:VALUE_BITS];
		op         = op_decode(character);
	end

	always_comb begin
		push       = accept && (!is_digit || ovf);
		push_value = acc_q;
		if (is_digit) begin
			push_tail.num_valid  = 1'b0;
			push_tail.tail_valid = 1'b1;
			push_tail.kind       = KIND_OVERFLOW;
			push_tail.code       = CODE_NONE;
		end else begin
			push_tail.num_valid  = nip_q;
			// a space closing a number gives the number alone
			push_tail.tail_valid = !(nip_q && character == CH_SPACE);
			push_tail.kind       = op.hit ? KIND_OPERATOR : KIND_INVALID;
			push_tail.code       = op.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nip_q <= 1'b0;
			acc_q <= '0;
		end else if (accept) begin
			if (is_digit && !ovf) begin
				nip_q <= 1'b1;
				acc_q <= prod[VALUE_BITS-1:0];
			end else begin
				nip_q <= 1'b0;
				acc_q <= '0;
			end
		end
	end

	a_idle_acc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!nip_q |-> acc_q == '0)
		else $error("accumulator not clear without a number in progress");

endmodule

FILE: design/rdt_fifo.sv
// Short queue between front and back of the RPN decimal tokenizer.
// Register array with read and write pointers; no package dependency.
module rdt_fifo #(
	parameter int DATA_BITS = 39,
	parameter int DEPTH     = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [DATA_BITS-1:0] push_data,
	input  logic                 pop,
	output logic [DATA_BITS-1:0] head,
	output logic                 full,
	output logic                 empty
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);

	logic [DATA_BITS-1:0] mem [DEPTH];
	logic [PTR_BITS-1:0]  wr_ptr_q;
	logic [PTR_BITS-1:0]  rd_ptr_q;
	logic [CNT_BITS-1:0]  count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = count_q == CNT_BITS'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(DEPTH))
		else $error("queue count above depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full queue");

endmodule

FILE: design/rdt_back.sv
// Back end of the RPN decimal tokenizer: turns queue entries into one or two
// tokens and holds them in the output register. Depends on rdt_pkg.
module rdt_back import rdt_pkg::*; #(
	parameter int VALUE_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  empty,
	input  logic [VALUE_BITS-1:0] head_value,
	input  rdt_tail_t             head_tail,
	output logic                  pop,
	output logic                  tok_valid,
	input  logic                  tok_stall,
	output logic [1:0]            token_kind,
	output logic [VALUE_BITS-1:0] number_value,
	output logic [3:0]            operator_code,
	output logic                  last_of_run
);

	logic      out_valid_q;
	logic      phase_q;
	logic      advance;
	logic      load;
	logic      emit_tail;
	rdt_kind_t kind_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [3:0] code_q;
	logic       last_q;

	always_comb begin
		advance   = !out_valid_q || !tok_stall;
		load      = advance && !empty;
		emit_tail = phase_q || !head_tail.num_valid;
		// drop the entry once its final token goes out
		pop       = load && (emit_tail || !head_tail.tail_valid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (advance) begin
			out_valid_q <= !empty;
			if (load) begin
				phase_q <= !emit_tail && head_tail.tail_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (emit_tail) begin
				kind_q  <= head_tail.kind;
				value_q <= '0;
				code_q  <= head_tail.code;
				last_q  <= 1'b1;
			end else begin
				kind_q  <= KIND_NUMBER;
				value_q <= head_value;
				code_q  <= CODE_NONE;
				last_q  <= !head_tail.tail_valid;
			end
		end
	end

	assign tok_valid     = out_valid_q;
	assign token_kind    = kind_q;
	assign number_value  = value_q;
	assign operator_code = code_q;
	assign last_of_run   = last_q;

	a_phase_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> !empty)
		else $error("second token pending with queue empty");

	a_value_only_number: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q != KIND_NUMBER |-> value_q == '0)
		else $error("non-number token carries a value");

endmodule

FILE: design/rpn_decimal_tokenizer.sv
// Top level of the RPN decimal tokenizer: front end, entry queue, back end.
// Depends on rdt_pkg, rdt_front, rdt_fifo and rdt_back.
//
// Use: characters enter on char_valid / char_stall with the code on character,
// one item per cycle while char_stall is low. Digits build a decimal number;
// the first non-digit closes it with a number token, followed by an operator
// or invalid-input token unless the character was a space. A number that
// would exceed the VALUE_BITS maximum gives an overflow token and is dropped.
// Tokens leave on tok_valid / tok_stall with token_kind, number_value,
// operator_code and last_of_run, which marks the final token of a character.
// Path: the queue is written at the edge that accepts a character, and the
// output register loads from the queue head when it may advance; a second
// token from the same entry follows once the first has moved on.
// Throughput: one character per cycle in, one token per cycle out, while no
// stall holds them; a character that closes a number and carries an operator
// gives two tokens, and the QUEUE_DEPTH-entry queue absorbs such bursts.
// Stall: while tok_stall is high the output token holds; the queue fills and
// char_stall rises only when it is full.
// Reset: arst_n clears the accumulator, the queue and the output valid.
module rpn_decimal_tokenizer import rdt_pkg::*; #(
	parameter int VALUE_BITS  = 31,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_stall,
	input  logic [7:0]            character,
	output logic                  tok_valid,
	input  logic                  tok_stall,
	output logic [1:0]            token_kind,
	output logic [VALUE_BITS-1:0] number_value,
	output logic [3:0]            operator_code,
	output logic                  last_of_run
);

	localparam int TAIL_BITS  = $bits(rdt_tail_t);
	localparam int ENTRY_BITS = VALUE_BITS + TAIL_BITS;

	logic                  full;
	logic                  empty;
	logic                  push;
	logic                  pop;
	logic [VALUE_BITS-1:0] push_value;
	rdt_tail_t             push_tail;
	logic [ENTRY_BITS-1:0] head;
	logic [VALUE_BITS-1:0] head_value;
	rdt_tail_t             head_tail;

	rdt_front #(.VALUE_BITS(VALUE_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.character  (character),
		.full       (full),
		.push       (push),
		.push_value (push_value),
		.push_tail  (push_tail)
	);

	rdt_fifo #(.DATA_BITS(ENTRY_BITS), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_value, push_tail}),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	assign head_value = head[ENTRY_BITS-1:TAIL_BITS];
	assign head_tail  = rdt_tail_t'(head[TAIL_BITS-1:0]);

	rdt_back #(.VALUE_BITS(VALUE_BITS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.empty         (empty),
		.head_value    (head_value),
		.head_tail     (head_tail),
		.pop           (pop),
		.tok_valid     (tok_valid),
		.tok_stall     (tok_stall),
		.token_kind    (token_kind),
		.number_value  (number_value),
		.operator_code (operator_code),
		.last_of_run   (last_of_run)
	);

endmodule
